### design/assert_macros.svh
// Assertion macros shared by the stream order design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define RSO_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// Check that a condition implies another in the next cycle.
`define RSO_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

### design/rso_pkg.sv
// Shared constants and types of the raster stream order core.
package rso_pkg;

  localparam int MAX_ROWS_DEF   = 64;
  localparam int MAX_COLS_DEF   = 64;
  localparam int ORDER_BITS_DEF = 8;

  localparam int CFG_W   = 7;
  localparam int IDX_W   = 12;
  localparam int OUT_W   = 8;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
  localparam logic             CFG_ROWS  = 1'b0;
  localparam logic             CFG_COLS  = 1'b1;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // stream flag pair {dir_valid, on_stream}
  localparam logic [1:0] STREAM_CELL = 2'b11;

  localparam logic [3:0] K_CENTRE    = 4'd4;
  localparam logic [3:0] K_LAST      = 4'd8;
  localparam logic [4:0] DIR_OPP_SUM = 5'd8;

  typedef struct packed {
    logic clear;
    logic fold;
  } merge_ctl_t;

endpackage

### design/rso_merge.sv
// Merge unit: folds contributor orders into one cell's stream order.
`include "assert_macros.svh"
module rso_merge
  import rso_pkg::*;
#(
  parameter int ORDER_BITS = ORDER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  merge_ctl_t            ctl_i,
  input  logic [ORDER_BITS-1:0] value_i,
  output logic [ORDER_BITS-1:0] order_o
);

  localparam logic [ORDER_BITS-1:0] TOP = '1;

  logic                  seen_q, seen_d;
  logic [ORDER_BITS-1:0] out_q, out_d, mx_q, mx_d;

  always_comb begin
    seen_d = seen_q;
    out_d  = out_q;
    mx_d   = mx_q;
    if (ctl_i.clear) begin
      seen_d = 1'b0;
      out_d  = ORDER_BITS'(1);
      mx_d   = '0;
    end else if (ctl_i.fold) begin
      seen_d = 1'b1;
      if (!seen_q || value_i > out_q) begin
        out_d = value_i;
        mx_d  = value_i;
      end else if (value_i == out_q) begin
        // equal order bumps the first maximum, saturating
        out_d = (mx_q == TOP) ? TOP : mx_q + ORDER_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else begin
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    mx_q  <= mx_d;
  end

  assign order_o = out_q;

  `RSO_ASSERT_NEXT(a_fold_nonzero, ctl_i.fold && value_i != '0, out_q != '0)

endmodule

### design/raster_stream_order_core.sv
// Top level: raster load, stream order sweep sequencer and read-back.
// A read result is registered after state S_RDW. The last load starts a clear pass over
// all MAX_ROWS*MAX_COLS cells, then repeated sweeps: S_CRD, S_CEV and S_FIN per cell, plus
// S_NRD and S_NEV per in-grid neighbor and S_NRD alone per off-grid or centre position for
// an unordered stream cell, until a sweep orders nothing; input is not ready meanwhile.
// Reset is asynchronous active low: control state clears, memories keep their contents.
`include "assert_macros.svh"
module raster_stream_order_core
  import rso_pkg::*;
#(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int ORDER_BITS = ORDER_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // cell_index[11:0], flow_dir[15:12], dir_valid[16], on_stream[17], zero fill
  input  logic [23:0]      s_axis_tdata_i,
  // req_type[0]
  input  logic             s_axis_tuser_i,
  input  logic             s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // order_value[7:0], order_present[8], zero fill
  output logic [15:0]      m_axis_tdata_o
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CLW   = $clog2(MAX_COLS + 1);
  localparam int NW    = $clog2(CELLS + 1);
  localparam int IW    = ((AW > IDX_W) ? AW : IDX_W) + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDW  = 4'd1;
  localparam logic [3:0] S_CLR  = 4'd2;
  localparam logic [3:0] S_CRD  = 4'd3;
  localparam logic [3:0] S_CEV  = 4'd4;
  localparam logic [3:0] S_NRD  = 4'd5;
  localparam logic [3:0] S_NEV  = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;

  // configuration
  logic [CFG_W-1:0] rows_q, cols_q;
  logic [RW-1:0]    er;
  logic [CLW-1:0]   ec;
  logic [NW-1:0]    ncells;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_RESET;
      cols_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_ROWS) rows_q <= cfg_wdata_i;
      if (cfg_idx_i == CFG_COLS) cols_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (rows_q == '0) er = RW'(1);
    else if (int'(rows_q) > MAX_ROWS) er = RW'(MAX_ROWS);
    else er = RW'(rows_q);
    if (cols_q == '0) ec = CLW'(1);
    else if (int'(cols_q) > MAX_COLS) ec = CLW'(MAX_COLS);
    else ec = CLW'(cols_q);
    ncells = NW'(NW'(er) * NW'(ec));
  end

  // input fields
  logic [IDX_W-1:0] cell_index;
  logic [3:0]       flow_dir;
  logic             dir_valid, on_stream;
  assign cell_index = s_axis_tdata_i[11:0];
  assign flow_dir   = s_axis_tdata_i[15:12];
  assign dir_valid  = s_axis_tdata_i[16];
  assign on_stream  = s_axis_tdata_i[17];

  // sequencer state
  logic [3:0]            st_q, st_d;
  logic [AW-1:0]         a_q, a_d;
  logic [RW-1:0]         r_q, r_d;
  logic [CLW-1:0]        c_q, c_d;
  logic [3:0]            k_q, k_d;
  logic [3:0]            cdir_q, cdir_d;
  logic                  prog_q, prog_d;
  logic                  computed_q, computed_d;
  logic                  rd_ok_q, rd_ok_d;
  logic                  mv_q, mv_d;
  logic [8:0]            mdata_q, mdata_d;
  logic                  skip_q;

  // memories
  logic [5:0]            dmem [CELLS];
  logic [ORDER_BITS:0]   omem [CELLS];
  logic [5:0]            drd_q;
  logic [ORDER_BITS:0]   ord_q;
  logic [AW-1:0]         raddr, daddr;
  logic                  dwe, owe;
  logic [ORDER_BITS:0]   owdata;

  // neighbor address and grid test
  logic          up, dn, lf, rt, in_grid, last_cell_sw;
  logic [AW:0]   nb_w;
  logic [AW-1:0] nb;
  logic          s_acc, in_range, contrib;
  logic [3:0]    ndir;
  logic [ORDER_BITS-1:0] merged;
  merge_ctl_t    mctl;

  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign in_range = IW'(cell_index) < IW'(ncells);
  assign daddr    = AW'(cell_index);

  always_comb begin
    up = (k_q < 4'd3);
    dn = (k_q > 4'd5);
    lf = (k_q == 4'd0) || (k_q == 4'd3) || (k_q == 4'd6);
    rt = (k_q == 4'd2) || (k_q == 4'd5) || (k_q == 4'd8);
    in_grid = (k_q != K_CENTRE)
           && !(up && r_q == '0)
           && !(dn && ((RW+1)'(r_q) + (RW+1)'(1)) >= (RW+1)'(er))
           && !(lf && c_q == '0)
           && !(rt && ((CLW+1)'(c_q) + (CLW+1)'(1)) >= (CLW+1)'(ec));
    nb_w = {1'b0, a_q};
    if (up) nb_w = nb_w - (AW+1)'(ec);
    if (dn) nb_w = nb_w + (AW+1)'(ec);
    if (lf) nb_w = nb_w - (AW+1)'(1);
    if (rt) nb_w = nb_w + (AW+1)'(1);
    nb = nb_w[AW-1:0];
    last_cell_sw = ((NW'(a_q) + NW'(1)) == ncells);
  end

  // neighbor drains here: points back toward this cell and is not its exact opposite
  assign ndir    = drd_q[5:2];
  assign contrib = (drd_q[1:0] == STREAM_CELL) && (ndir == (K_LAST - k_q))
                && ((5'(ndir) + 5'(cdir_q)) != DIR_OPP_SUM);

  always_comb begin
    unique case (st_q)
      S_IDLE:  raddr = daddr;
      S_NRD:   raddr = nb;
      default: raddr = a_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dwe) dmem[daddr] <= {flow_dir, dir_valid, on_stream};
    drd_q <= dmem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (owe) omem[a_q] <= owdata;
    ord_q <= omem[raddr];
  end

  rso_merge #(.ORDER_BITS(ORDER_BITS)) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mctl),
    .value_i (ord_q[ORDER_BITS-1:0]),
    .order_o (merged)
  );

  assign s_axis_tready_o = (st_q == S_IDLE) && (!mv_q || m_axis_tready_i);

  always_comb begin
    st_d       = st_q;
    a_d        = a_q;
    r_d        = r_q;
    c_d        = c_q;
    k_d        = k_q;
    cdir_d     = cdir_q;
    prog_d     = prog_q;
    computed_d = computed_q;
    rd_ok_d    = rd_ok_q;
    mv_d       = mv_q && !m_axis_tready_i;
    mdata_d    = mdata_q;
    dwe        = 1'b0;
    owe        = 1'b0;
    owdata     = '0;
    mctl       = '0;
    unique case (st_q)
      S_IDLE: begin
        if (s_acc) begin
          if (s_axis_tuser_i == REQ_LOAD) begin
            computed_d = 1'b0;
            dwe        = in_range;
            if (s_axis_tlast_i) begin
              a_d  = '0;
              st_d = S_CLR;
            end
          end else begin
            rd_ok_d = computed_q && in_range;
            st_d    = S_RDW;
          end
        end
      end
      S_RDW: begin
        mv_d = 1'b1;
        if (rd_ok_q && drd_q[1:0] == STREAM_CELL) begin
          mdata_d[8] = 1'b1;
          if (ORDER_BITS > OUT_W && ord_q[ORDER_BITS-1:0] > ORDER_BITS'(255))
            mdata_d[7:0] = 8'hFF;
          else
            mdata_d[7:0] = OUT_W'(ord_q[ORDER_BITS-1:0]);
        end else begin
          mdata_d = '0;
        end
        st_d = S_IDLE;
      end
      S_CLR: begin
        // clear the whole store so that a later grid size reads no stale order
        owe = 1'b1;
        if (a_q == AW'(CELLS - 1)) begin
          a_d    = '0;
          r_d    = '0;
          c_d    = '0;
          prog_d = 1'b0;
          st_d   = S_CRD;
        end else begin
          a_d = a_q + AW'(1);
        end
      end
      S_CRD: st_d = S_CEV;
      S_CEV: begin
        if (drd_q[1:0] == STREAM_CELL && !ord_q[ORDER_BITS]) begin
          cdir_d     = drd_q[5:2];
          k_d        = '0;
          mctl.clear = 1'b1;
          st_d       = S_NRD;
        end else begin
          st_d = S_FIN;
        end
      end
      S_NRD: begin
        if (in_grid) st_d = S_NEV;
        else if (k_q == K_LAST) st_d = S_FIN;
        else k_d = k_q + 4'd1;
      end
      S_NEV: begin
        mctl.fold = contrib && ord_q[ORDER_BITS];
        if (contrib && !ord_q[ORDER_BITS]) begin
          // contributor still pending: skip this cell for now
          k_d  = K_LAST;
          cdir_d = cdir_q;
          st_d = S_FIN;
          mctl.clear = 1'b1;
          prog_d = prog_q;
        end else if (k_q == K_LAST) begin
          st_d = S_FIN;
        end else begin
          k_d  = k_q + 4'd1;
          st_d = S_NRD;
        end
      end
      S_FIN: begin
        st_d = S_CRD;
        if (!skip_q && merged != '0) begin
          owe    = 1'b1;
          owdata = {1'b1, merged};
          prog_d = 1'b1;
        end
        if (last_cell_sw) begin
          a_d = '0;
          r_d = '0;
          c_d = '0;
          if (!(prog_d)) begin
            computed_d = 1'b1;
            st_d       = S_IDLE;
          end
          prog_d = 1'b0;
        end else begin
          a_d = a_q + AW'(1);
          if ((CLW+1)'(c_q) + (CLW+1)'(1) == (CLW+1)'(ec)) begin
            c_d = '0;
            r_d = r_q + RW'(1);
          end else begin
            c_d = c_q + CLW'(1);
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // blocked-cell flag: keep the merge result from being written on a skipped cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= 1'b0;
    end else if (st_q == S_CEV) begin
      skip_q <= !(drd_q[1:0] == STREAM_CELL && !ord_q[ORDER_BITS]);
    end else if (st_q == S_NEV && contrib && !ord_q[ORDER_BITS]) begin
      skip_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      a_q        <= '0;
      r_q        <= '0;
      c_q        <= '0;
      k_q        <= '0;
      prog_q     <= 1'b0;
      computed_q <= 1'b0;
      rd_ok_q    <= 1'b0;
      mv_q       <= 1'b0;
    end else begin
      st_q       <= st_d;
      a_q        <= a_d;
      r_q        <= r_d;
      c_q        <= c_d;
      k_q        <= k_d;
      prog_q     <= (st_q == S_FIN && skip_q) ? (last_cell_sw ? 1'b0 : prog_q) : prog_d;
      computed_q <= (st_q == S_FIN && skip_q && last_cell_sw) ? !prog_q : computed_d;
      rd_ok_q    <= rd_ok_d;
      mv_q       <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cdir_q  <= cdir_d;
    mdata_q <= mdata_d;
  end

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = {7'b0, mdata_q};

  `RSO_ASSERT(a_clear_not_computed, st_q != S_CLR || !computed_q)
  `RSO_ASSERT(a_ready_only_idle, !s_axis_tready_o || st_q == S_IDLE)
  `RSO_ASSERT_NEXT(a_read_result, s_acc && s_axis_tuser_i == REQ_READ,
                   st_q == S_RDW && !mv_q)

endmodule

### tb/sv/raster_stream_order_core_tb.sv
// Self-checking testbench of the raster stream order core: grid loads, order sweeps, reads.
module raster_stream_order_core_tb
  import rso_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_MAX  = MAX_ROWS_DEF * MAX_COLS_DEF;
  localparam int ORDER_TOP = (1 << ORDER_BITS_DEF) - 1;
  localparam int SETTLE    = 20;
  localparam int ROW_STEP[9] = '{-1, -1, -1, 0, 0, 0, 1, 1, 1};
  localparam int COL_STEP[9] = '{-1, 0, 1, -1, 0, 1, -1, 0, 1};

  typedef struct packed {
    logic             req;
    logic [IDX_W-1:0] idx;
    logic [3:0]       dir;
    logic             dir_ok;
    logic             on_strm;
    logic             last;
  } cell_req_t;

  typedef struct packed {
    logic             present;
    logic [OUT_W-1:0] order;
  } order_rsp_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic             cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;
  logic             s_valid;
  logic             s_ready;
  logic             m_valid;
  logic             m_ready;
  logic [15:0]      m_data;
  cell_req_t        cur_req;
  logic             req_taken;

  cell_req_t  req_q[$];
  order_rsp_t order_q[$];
  int         errors;
  int         n_items;
  int         src_idle_pct;
  int         snk_stall_pct;

  // predictor state
  logic [3:0]  dir_mem[GRID_MAX];
  logic [1:0]  strm_mem[GRID_MAX];
  int          ord_mem[GRID_MAX];
  int          pend[GRID_MAX];
  int          work[GRID_MAX];
  bit          computed;
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;

  raster_stream_order_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  ({6'd0, cur_req.on_strm, cur_req.dir_ok, cur_req.dir, cur_req.idx}),
    .s_axis_tuser_i  (cur_req.req),
    .s_axis_tlast_i  (cur_req.last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int top);
    int r;
    r = v;
    if (r < 1) r = 1;
    if (r > top) r = top;
    return r;
  endfunction

  function automatic bit is_stream(input int a);
    return strm_mem[a] == STREAM_CELL;
  endfunction

  // cell that stream cell a drains into, or -1
  function automatic int drain_of(input int a, input int rows, input int cols);
    int d, r, c, t;
    d = dir_mem[a];
    if (d > K_LAST || d == K_CENTRE) return -1;
    r = a / cols + ROW_STEP[d];
    c = a % cols + COL_STEP[d];
    if (r < 0 || r >= rows || c < 0 || c >= cols) return -1;
    t = r * cols + c;
    if (!is_stream(t)) return -1;
    if (d + int'(dir_mem[t]) == int'(DIR_OPP_SUM)) return -1;
    return t;
  endfunction

  function automatic int merged_order(input int a, input int rows, input int cols);
    int cnt, res, mx, k, tr, tc, t, v;
    cnt = 0;
    res = 1;
    mx  = 0;
    for (k = 0; k < 9; k++) begin
      tr = a / cols + ROW_STEP[k];
      tc = a % cols + COL_STEP[k];
      if (tr < 0 || tr >= rows || tc < 0 || tc >= cols) continue;
      t = tr * cols + tc;
      if (!is_stream(t) || drain_of(t, rows, cols) != a) continue;
      v = ord_mem[t];
      if (v == 0) continue;
      cnt++;
      if (cnt == 1 || v > res) begin
        res = v;
        mx  = v;
      end else if (v == res) begin
        res = (mx >= ORDER_TOP) ? ORDER_TOP : mx + 1;
      end
    end
    return res;
  endfunction

  // order the stream cells, upstream first; cells on a loop get no order
  function automatic void order_grid();
    int rows, cols, n, a, t, c, head, tail;
    rows = clamp_dim(rows_reg, MAX_ROWS_DEF);
    cols = clamp_dim(cols_reg, MAX_COLS_DEF);
    n = rows * cols;
    head = 0;
    tail = 0;
    for (a = 0; a < GRID_MAX; a++) begin
      ord_mem[a] = 0;
      pend[a] = 0;
    end
    for (a = 0; a < n; a++)
      if (is_stream(a)) begin
        t = drain_of(a, rows, cols);
        if (t >= 0) pend[t]++;
      end
    for (a = 0; a < n; a++)
      if (is_stream(a) && pend[a] == 0) work[tail++] = a;
    while (head < tail) begin
      c = work[head++];
      ord_mem[c] = merged_order(c, rows, cols);
      t = drain_of(c, rows, cols);
      if (t >= 0 && pend[t] > 0) begin
        pend[t]--;
        if (pend[t] == 0 && tail < GRID_MAX) work[tail++] = t;
      end
    end
  endfunction

  function automatic void predict_request(input cell_req_t it);
    int ncells;
    order_rsp_t rsp;
    ncells = clamp_dim(rows_reg, MAX_ROWS_DEF) * clamp_dim(cols_reg, MAX_COLS_DEF);
    if (it.req == REQ_LOAD) begin
      if (computed) begin
        for (int a = 0; a < GRID_MAX; a++) ord_mem[a] = 0;
        computed = 1'b0;
      end
      if (int'(it.idx) < ncells) begin
        dir_mem[it.idx]  = it.dir;
        strm_mem[it.idx] = {it.dir_ok, it.on_strm};
      end
      if (it.last) begin
        order_grid();
        computed = 1'b1;
      end
    end else begin
      rsp = '0;
      if (computed && int'(it.idx) < ncells && is_stream(it.idx)) begin
        rsp.order   = (ord_mem[it.idx] > 255) ? 8'd255 : OUT_W'(ord_mem[it.idx]);
        rsp.present = 1'b1;
      end
      order_q.push_back(rsp);
    end
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni && s_valid && s_ready) begin
      predict_request(cur_req);
      req_taken <= 1'b1;
    end else begin
      req_taken <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_valid || req_taken) begin
        if (req_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_req <= req_q.pop_front();
          s_valid <= 1'b1;
        end else begin
          s_valid <= 1'b0;
        end
      end
      m_ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    order_rsp_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (order_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual order %0d present %0b",
                 $realtime, m_data[7:0], m_data[8]);
      end else begin
        want = order_q.pop_front();
        if (m_data[7:0] !== want.order) begin
          errors++;
          $display("%0t: order_value mismatch, expected %0d, actual %0d",
                   $realtime, want.order, m_data[7:0]);
        end
        if (m_data[8] !== want.present) begin
          errors++;
          $display("%0t: order_present mismatch, expected %0b, actual %0b",
                   $realtime, want.present, m_data[8]);
        end
      end
    end
  end

  task automatic push_load(input int idx, input int dir, input bit ok, input bit strm,
                           input bit last);
    cell_req_t it;
    it.req     = REQ_LOAD;
    it.idx     = IDX_W'(idx);
    it.dir     = 4'(dir);
    it.dir_ok  = ok;
    it.on_strm = strm;
    it.last    = last;
    req_q.push_back(it);
    n_items++;
  endtask

  task automatic push_read(input int idx);
    cell_req_t it;
    it = '0;
    it.req = REQ_READ;
    it.idx = IDX_W'(idx);
    it.dir = 4'($urandom_range(15));
    it.dir_ok = 1'($urandom_range(1));
    it.on_strm = 1'($urandom_range(1));
    it.last = 1'($urandom_range(1));
    req_q.push_back(it);
    n_items++;
  endtask

  task automatic push_rand_load(input int idx, input bit last);
    int sel, dir;
    sel = $urandom_range(99);
    if (sel < 70) dir = $urandom_range(8, 6);
    else if (sel < 90) dir = $urandom_range(8);
    else dir = $urandom_range(15);
    push_load(idx, dir, $urandom_range(99) < 95, $urandom_range(99) < 85, last);
  endtask

  // hold until the block has drained everything and is back to idle
  task automatic drain_all();
    while (req_q.size() > 0 || s_valid || order_q.size() > 0 || !s_ready)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input int val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_W'(val);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    if (idx == CFG_ROWS) rows_reg = CFG_W'(val);
    else cols_reg = CFG_W'(val);
  endtask

  task automatic run_grid(input int rows_v, input int cols_v, input int mode);
    int ncells, perm[$], j, tmp, extra;
    drain_all();
    write_cfg(CFG_ROWS, rows_v);
    write_cfg(CFG_COLS, cols_v);
    case (mode % 4)
      0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      1: begin src_idle_pct = 54; snk_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  snk_stall_pct = 54; end
      default: begin src_idle_pct = 35; snk_stall_pct = 35; end
    endcase
    ncells = clamp_dim(rows_reg, MAX_ROWS_DEF) * clamp_dim(cols_reg, MAX_COLS_DEF);
    perm.delete();
    for (int a = 0; a < ncells; a++) perm.push_back(a);
    for (int a = ncells - 1; a > 0; a--) begin
      j = $urandom_range(a);
      tmp = perm[a];
      perm[a] = perm[j];
      perm[j] = tmp;
    end
    extra = int'($urandom_range(99) < 20);
    for (int a = 0; a < ncells; a++) begin
      if (a > 0 && $urandom_range(99) < 10) push_read($urandom_range(ncells - 1));
      if ($urandom_range(99) < 3) push_rand_load($urandom_range(4095, ncells), 1'b0);
      push_rand_load(perm[a], !extra && a == ncells - 1);
    end
    if (extra) push_rand_load($urandom_range(4095, ncells), 1'b1);
    for (int a = 0; a < ncells; a++) push_read($urandom_range(99) < 90 ? a : $urandom_range(4095));
    push_read($urandom_range(ncells - 1));
    if ($urandom_range(99) < 30) begin
      // reload two cells with a read between them, then recompute
      push_rand_load($urandom_range(ncells - 1), 1'b0);
      push_read($urandom_range(ncells - 1));
      push_rand_load($urandom_range(ncells - 1), 1'b1);
      for (int a = 0; a < ncells; a++) push_read(a);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_ROWS;
    cfg_wdata     = '0;
    s_valid       = 1'b0;
    m_ready       = 1'b0;
    cur_req       = '0;
    req_taken     = 1'b0;
    errors        = 0;
    n_items       = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    computed      = 1'b0;
    rows_reg      = CFG_RESET;
    cols_reg      = CFG_RESET;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reads before any computation
    push_read(0);
    push_read(4095);
    drain_all();

    // 3x3: merges, centre code, wide code, opposite pair, non-stream, no-data direction
    write_cfg(CFG_ROWS, 3);
    write_cfg(CFG_COLS, 3);
    push_load(0, 8, 1, 1, 0);
    push_load(1, 7, 1, 1, 0);
    push_load(2, 6, 1, 1, 0);
    push_load(3, 5, 1, 1, 0);
    push_load(4, 5, 1, 1, 0);
    push_load(5, 3, 1, 1, 0);
    push_load(6, 5, 0, 1, 0);
    push_load(4095, 15, 1, 1, 0);
    push_read(0);
    push_load(7, 12, 1, 1, 0);
    push_load(8, 4, 1, 0, 1);
    for (int a = 0; a < 10; a++) push_read(a);
    push_read(4095);
    push_load(6, 5, 1, 1, 0);
    push_read(1);
    push_load(0, 0, 1, 1, 1);
    for (int a = 0; a < 9; a++) push_read(a);
    drain_all();

    // 2x2 ring: a cycle never gets an order
    write_cfg(CFG_ROWS, 2);
    write_cfg(CFG_COLS, 2);
    push_load(0, 5, 1, 1, 0);
    push_load(1, 7, 1, 1, 0);
    push_load(3, 3, 1, 1, 0);
    push_load(2, 1, 1, 1, 1);
    for (int a = 0; a < 4; a++) push_read(a);

    run_grid(0, 64, 0);
    run_grid(127, 1, 1);
    run_grid(64, 1, 2);
    run_grid(1, 1, 3);
    run_grid(8, 8, 0);
    for (int s = 0; n_items < 1850; s++)
      run_grid($urandom_range(10, 1), $urandom_range(10, 1), s);
    run_grid(0, 0, 0);
    drain_all();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
